/* sv/uart_ring_buffer_port_unit_defines.svh */
// assertion macros for the serial port buffering block
`ifndef UART_RING_BUFFER_PORT_UNIT_DEFINES_SVH
`define UART_RING_BUFFER_PORT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define URB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart ring buffer check failed");
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart ring buffer check failed");
`else
`define URB_ASSERT_SAME(label, clk, rst, ante, cons)
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/urb_pkg.sv */
package urb_pkg;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 64;
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TIMER_W = 16;
  localparam int CFG_W = 16;

  localparam logic [TIMER_W-1:0] IDLE_RELOAD_RST = TIMER_W'(10);

  localparam logic [2:0] MODE_HOST_WRITE = 3'd0;
  localparam logic [2:0] MODE_HOST_READ  = 3'd1;
  localparam logic [2:0] MODE_LINE_RX    = 3'd2;
  localparam logic [2:0] MODE_TX_READY   = 3'd3;
  localparam logic [2:0] MODE_TICK       = 3'd4;
  localparam logic [2:0] MODE_START_SEND = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic CFG_IDLE_RELOAD = 1'b0;
  localparam logic CFG_HALF_DUPLEX = 1'b1;

  typedef struct packed {
    logic             we;
    logic [TX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [TX_AW-1:0] raddr;
  } tx_req_t;

  typedef struct packed {
    logic             we;
    logic [RX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RX_AW-1:0] raddr;
  } rx_req_t;

  typedef struct packed {
    logic       valid;
    logic       pop_tx;
    logic       pop_rx;
    logic [1:0] status;
    logic       line_tx_valid;
    logic       driver_enable;
    logic       sending;
    logic       frame_end;
  } res_t;

endpackage

/* sv/urb_ram.sv */
module urb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/urb_ctrl.sv */
module urb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [2:0]                  mode,
  input  logic [7:0]                  data_in,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [urb_pkg::CFG_W-1:0]   cfg_data,
  output urb_pkg::tx_req_t            tx_req,
  output urb_pkg::rx_req_t            rx_req,
  output urb_pkg::res_t               res
);

  import urb_pkg::*;

  logic [TX_AW-1:0]   tx_head, tx_head_next;
  logic [TX_AW-1:0]   tx_tail, tx_tail_next;
  logic [TX_CW-1:0]   tx_count, tx_count_next;
  logic [RX_AW-1:0]   rx_head, rx_head_next;
  logic [RX_AW-1:0]   rx_tail, rx_tail_next;
  logic [RX_CW-1:0]   rx_count, rx_count_next;
  logic [TIMER_W-1:0] idle_timer, idle_timer_next;
  logic               sending_flag, sending_flag_next;
  logic               driver_dir, driver_dir_next;
  logic [TIMER_W-1:0] idle_reload;
  logic               half_duplex;
  logic [1:0]         status;
  logic               pop_tx, pop_rx, push_tx, push_rx, frame_end;

  always_comb begin
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    tx_count_next     = tx_count;
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    rx_count_next     = rx_count;
    idle_timer_next   = idle_timer;
    sending_flag_next = sending_flag;
    driver_dir_next   = driver_dir;
    status            = ST_OK;
    pop_tx            = 1'b0;
    pop_rx            = 1'b0;
    push_tx           = 1'b0;
    push_rx           = 1'b0;
    frame_end         = 1'b0;
    unique case (mode)
      MODE_HOST_WRITE: begin
        if (tx_count != TX_CW'(TX_DEPTH)) begin
          push_tx       = 1'b1;
          tx_tail_next  = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
          tx_count_next = tx_count + 1'b1;
        end else begin
          status = ST_FULL;
        end
      end
      MODE_HOST_READ: begin
        if (rx_count != '0) begin
          pop_rx        = 1'b1;
          rx_head_next  = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
          rx_count_next = rx_count - 1'b1;
        end else begin
          status = ST_EMPTY;
        end
      end
      MODE_LINE_RX: begin
        if (half_duplex && sending_flag) begin
          status = ST_IGNORED;
        end else begin
          if (rx_count != RX_CW'(RX_DEPTH)) begin
            push_rx       = 1'b1;
            rx_tail_next  = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
            rx_count_next = rx_count + 1'b1;
          end else begin
            status = ST_FULL;
          end
          idle_timer_next = idle_reload;
        end
      end
      MODE_TICK: begin
        if (idle_timer != '0) begin
          idle_timer_next = idle_timer - 1'b1;
          frame_end       = (idle_timer == TIMER_W'(1));
        end
      end
      MODE_TX_READY, MODE_START_SEND: begin
        if (mode == MODE_START_SEND) begin
          driver_dir_next = 1'b1;
        end
        if (tx_count != '0) begin
          pop_tx            = 1'b1;
          tx_head_next      = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
          tx_count_next     = tx_count - 1'b1;
          sending_flag_next = 1'b1;
        end else begin
          status            = ST_EMPTY;
          driver_dir_next   = 1'b0;
          sending_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head      <= '0;
      tx_tail      <= '0;
      tx_count     <= '0;
      rx_head      <= '0;
      rx_tail      <= '0;
      rx_count     <= '0;
      idle_timer   <= '0;
      sending_flag <= 1'b0;
      driver_dir   <= 1'b0;
    end else if (accept) begin
      tx_head      <= tx_head_next;
      tx_tail      <= tx_tail_next;
      tx_count     <= tx_count_next;
      rx_head      <= rx_head_next;
      rx_tail      <= rx_tail_next;
      rx_count     <= rx_count_next;
      idle_timer   <= idle_timer_next;
      sending_flag <= sending_flag_next;
      driver_dir   <= driver_dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_reload <= IDLE_RELOAD_RST;
      half_duplex <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_RELOAD: idle_reload <= cfg_data[TIMER_W-1:0];
        CFG_HALF_DUPLEX: half_duplex <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // memory requests go out in the accept cycle, read data is registered in the ram and lands in the cycle after
  assign tx_req.we    = accept & push_tx;
  assign tx_req.waddr = tx_tail;
  assign tx_req.wdata = data_in;
  assign tx_req.re    = accept & pop_tx;
  assign tx_req.raddr = tx_head;

  assign rx_req.we    = accept & push_rx;
  assign rx_req.waddr = rx_tail;
  assign rx_req.wdata = data_in;
  assign rx_req.re    = accept & pop_rx;
  assign rx_req.raddr = rx_head;

  assign res.valid         = accept;
  assign res.pop_tx        = pop_tx;
  assign res.pop_rx        = pop_rx;
  assign res.status        = status;
  assign res.line_tx_valid = pop_tx;
  assign res.driver_enable = driver_dir_next;
  assign res.sending       = sending_flag_next;
  assign res.frame_end     = frame_end;

endmodule

/* sv/uart_ring_buffer_port_unit.sv */
// channel   signals                               beat taken when
// command   start, busy, mode, data_in            start high and busy low at clk rise
// result    done, data_out, status, line_tx_valid done high (one cycle, no back-pressure)
//           driver_enable, sending, frame_end
// config    cfg_we, cfg_index, cfg_data           cfg_we high at clk rise
//
// a result shows up in the cycle after its command edge: the cycle of the fifo ram read
// one command per cycle; pointer and flag updates finish in the accept cycle
// busy stays low, results are never held off
// rst (synchronous) empties both fifos and restores idle_reload to 10, half_duplex to 0
`include "uart_ring_buffer_port_unit_defines.svh"

module uart_ring_buffer_port_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                mode,
  input  logic [7:0]                data_in,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [urb_pkg::CFG_W-1:0] cfg_data,
  output logic                      done,
  output logic [7:0]                data_out,
  output logic [1:0]                status,
  output logic                      line_tx_valid,
  output logic                      driver_enable,
  output logic                      sending,
  output logic                      frame_end
);

  import urb_pkg::*;

  logic       accept;
  tx_req_t    tx_req;
  rx_req_t    rx_req;
  res_t       res;
  res_t       res_q;
  logic [7:0] tx_rdata, rx_rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .data_in   (data_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tx_req    (tx_req),
    .rx_req    (rx_req),
    .res       (res)
  );

  urb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  urb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_q <= '0;
    end else begin
      res_q <= res;
    end
  end

  assign done          = res_q.valid;
  assign data_out      = res_q.pop_tx ? tx_rdata : (res_q.pop_rx ? rx_rdata : 8'd0);
  assign status        = res_q.status;
  assign line_tx_valid = res_q.line_tx_valid;
  assign driver_enable = res_q.driver_enable;
  assign sending       = res_q.sending;
  assign frame_end     = res_q.frame_end;

  `URB_ASSERT_NEXT(a_beat_follows, clk, rst, accept, done)
  `URB_ASSERT_SAME(a_single_pop, clk, rst, done, !(res_q.pop_tx && res_q.pop_rx))
  `URB_ASSERT_SAME(a_tx_sets_sending, clk, rst, done && line_tx_valid,
                   sending && status == ST_OK)
  `URB_ASSERT_SAME(a_empty_zero, clk, rst, done && status == ST_EMPTY, data_out == 8'd0)

endmodule
